@@ hdl/umem_pkg.sv @@
package umem_pkg;

    // Number of bytes kept from the tail of the current path segment.
    localparam int unsigned WINDOW_BYTES = 5;
    localparam int unsigned WINDOW_W     = 8 * WINDOW_BYTES;
    localparam int unsigned LEN_W        = 3;
    localparam logic [LEN_W-1:0] LEN_MAX = 3'd7;
    localparam int unsigned NUM_EXT      = 20;

    // Byte codes that steer the path parser.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Tracker state handed to the extension matcher.
    typedef struct packed {
        logic [WINDOW_W-1:0] window;
        logic [LEN_W-1:0]    seg_len;
    } tail_state_t;

    // One extension: lowercase bytes with the dot, newest byte lowest.
    typedef struct packed {
        logic [WINDOW_W-1:0] pattern;
        logic [LEN_W-1:0]    size;
    } ext_entry_t;

    localparam ext_entry_t EXT_TABLE [NUM_EXT] = '{
        '{40'h002E617669, 3'd4},  // .avi
        '{40'h002E6D7034, 3'd4},  // .mp4
        '{40'h002E6D6B76, 3'd4},  // .mkv
        '{40'h2E7765626D, 3'd5},  // .webm
        '{40'h002E6D6F76, 3'd4},  // .mov
        '{40'h002E6E6476, 3'd4},  // .ndv
        '{40'h002E336770, 3'd4},  // .3gp
        '{40'h002E6F6776, 3'd4},  // .ogv
        '{40'h002E6D7033, 3'd4},  // .mp3
        '{40'h002E776176, 3'd4},  // .wav
        '{40'h002E6D3461, 3'd4},  // .m4a
        '{40'h002E6F6767, 3'd4},  // .ogg
        '{40'h2E666C6163, 3'd5},  // .flac
        '{40'h002E616163, 3'd4},  // .aac
        '{40'h002E616D72, 3'd4},  // .amr
        '{40'h002E6A7067, 3'd4},  // .jpg
        '{40'h2E6A706567, 3'd5},  // .jpeg
        '{40'h002E706E67, 3'd4},  // .png
        '{40'h002E676966, 3'd4},  // .gif
        '{40'h002E626D70, 3'd4}   // .bmp
    };

    // ASCII lowercase: only 'A' through 'Z' change.
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ hdl/umem_tail_tracker.sv @@
module umem_tail_tracker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,      // one item is applied this cycle
    input  logic [7:0]            ch,
    input  logic                  end_mark,
    output umem_pkg::tail_state_t state
);

    umem_pkg::tail_state_t state_reg, state_next;
    logic path_ended_reg, path_ended_next;

    // Per-byte update of the segment tail, the length and the path end flag.
    always_comb begin
        state_next      = state_reg;
        path_ended_next = path_ended_reg;
        if (step) begin
            if (end_mark) begin
                state_next      = '0;
                path_ended_next = 1'b0;
            end else if (!path_ended_reg) begin
                if (ch == umem_pkg::CH_QUERY || ch == umem_pkg::CH_HASH ||
                    ch == umem_pkg::CH_NUL) begin
                    path_ended_next = 1'b1;
                end else if (ch == umem_pkg::CH_SLASH) begin
                    state_next = '0;
                end else begin
                    state_next.window = {state_reg.window[umem_pkg::WINDOW_W-9:0],
                                         umem_pkg::fold_case(ch)};
                    if (state_reg.seg_len != umem_pkg::LEN_MAX) begin
                        state_next.seg_len = state_reg.seg_len + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= '0;
            path_ended_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            path_ended_reg <= path_ended_next;
        end
    end

    assign state = state_reg;

endmodule

@@ hdl/umem_ext_match.sv @@
module umem_ext_match (
    input  umem_pkg::tail_state_t state,
    output logic                  hit
);

    // Compare the tail against every extension in parallel.
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < umem_pkg::NUM_EXT; k++) begin
            if (state.seg_len >= umem_pkg::EXT_TABLE[k].size) begin
                if (umem_pkg::EXT_TABLE[k].size == 3'd5) begin
                    if (state.window == umem_pkg::EXT_TABLE[k].pattern) begin
                        hit = 1'b1;
                    end
                end else begin
                    if (state.window[31:0] == umem_pkg::EXT_TABLE[k].pattern[31:0]) begin
                        hit = 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ hdl/url_media_extension_matcher_unit.sv @@
// Takes a URL one byte per transfer on the slave channel and closes it with a
// transfer that has s_axis_tlast set (its data byte is ignored). Bytes after the
// first '?', '#' or zero byte are ignored, and each '/' starts a new segment.
// For each closing transfer one result transfer follows, whose bit 0 says
// whether the last segment ends in one of twenty media extensions, case
// ignored. A byte transfer is taken every cycle unless the input stalls. A
// result passes the input register and the one-entry result register. Only a
// closing transfer can stall it, and only while the previous result is unclaimed.
module url_media_extension_matcher_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tlast,   // end_mark
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] playable, [7:1] zero
);

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_end_reg;
    logic       advance;
    logic       out_valid_reg;
    logic       playable_reg;
    logic       hit;
    umem_pkg::tail_state_t tail_state;

    // The registered item moves on unless it is a closing item facing a full
    // result register.
    assign advance       = !(in_valid_reg && in_end_reg && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_ch_reg  <= s_axis_tdata;
            in_end_reg <= s_axis_tlast;
        end
    end

    umem_tail_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (in_valid_reg && advance),
        .ch       (in_ch_reg),
        .end_mark (in_end_reg),
        .state    (tail_state)
    );

    umem_ext_match u_match (
        .state (tail_state),
        .hit   (hit)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_valid_reg && in_end_reg && advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && in_end_reg && advance) begin
            playable_reg <= hit;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, playable_reg};

    // A new result appears only after a closing item has been processed.
    a_result_from_end : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_end_reg && advance))
        else $error("result raised without a closing item");

    // The segment state is cleared right after a closing item.
    a_clear_after_end : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_end_reg && advance) |=> (tail_state == '0))
        else $error("tail state not cleared after closing item");

    // The input stalls only for a closing item blocked by a pending result.
    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && in_end_reg && out_valid_reg))
        else $error("input stalled without cause");

endmodule
